[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset
`define PTS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// Task scheduler package
// Sizes, codes and transaction types shared by the scheduler modules.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Number of task slots; the idle slot sits at index TASKS
  localparam int TASKS      = 8;
  localparam int SlotW      = $clog2(TASKS);
  localparam int TaskIdxW   = $clog2(TASKS + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [TaskIdxW-1:0] TaskIdle = TaskIdxW'(TASKS);

  // Event codes on the input mode field
  localparam logic [2:0] ModeTick    = 3'd0;
  localparam logic [2:0] ModeSched   = 3'd1;
  localparam logic [2:0] ModeCreate  = 3'd2;
  localparam logic [2:0] ModeDelay   = 3'd3;
  localparam logic [2:0] ModeBlock   = 3'd4;
  localparam logic [2:0] ModeUnblock = 3'd5;

  // Per-slot task state
  typedef enum logic [1:0] {
    StRun  = 2'd0,
    StBlk  = 2'd1,
    StRdy  = 2'd2,
    StFree = 2'd3
  } task_state_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusPrioZero = 2'd1,
    StatusNoSlot   = 2'd2
  } status_e;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OpTick       = 3'd0,
    OpSched      = 3'd1,
    OpCreate     = 3'd2,
    OpRejectPrio = 3'd3,
    OpDelay      = 3'd4,
    OpBlock      = 3'd5,
    OpUnblock    = 3'd6,
    OpNop        = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  task_id;
    logic [7:0]  priority_req;
    logic [31:0] target_tick;
  } in_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic [1:0]  status;
    logic [2:0]  new_task;
    logic [31:0] tick_count;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [7:0]       prio;
    logic [31:0]      target;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/pts_front.sv]
// ----------------------------------------------------------------------------
// Scheduler front end
// Registers incoming events and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module pts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pts_pkg::in_t      in_data_i,
  input  pts_pkg::q_status_t q_status_i,
  output logic              push_o,
  output pts_pkg::cmd_t     cmd_o
);
  import pts_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  // Hold a classified command until the queue takes it
  assign push_o     = valid_q && !q_status_i.full;
  assign in_stall_o = valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_o      = cmd_q;

  // Classify the event
  always_comb begin
    cmd_d.slot   = SlotW'(in_data_i.task_id);
    cmd_d.prio   = in_data_i.priority_req;
    cmd_d.target = in_data_i.target_tick;
    unique case (in_data_i.mode)
      ModeTick:   cmd_d.op = OpTick;
      ModeSched:  cmd_d.op = OpSched;
      ModeCreate: cmd_d.op = (in_data_i.priority_req == 8'd0) ? OpRejectPrio : OpCreate;
      ModeDelay:  cmd_d.op = OpDelay;
      ModeBlock:  cmd_d.op = OpBlock;
      ModeUnblock: begin
        // out-of-range slot is a no-op
        cmd_d.op = ({29'd0, in_data_i.task_id} < 32'(TASKS)) ? OpUnblock : OpNop;
      end
      default:    cmd_d.op = OpNop;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/pts_queue.sv]
// ----------------------------------------------------------------------------
// Scheduler command queue
// Short FIFO decoupling the classifying front end from the executing back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pts_pkg::cmd_t      push_data_i,
  input  logic               pop_i,
  output pts_pkg::cmd_t      pop_data_o,
  output pts_pkg::q_status_t status_o
);
  import pts_pkg::*;

  cmd_t             mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem[rd_ptr_q];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_d = push_i ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = QCntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = QCntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  `PTS_ASSERT_NEVER(a_q_pop_empty, pop_i && status_o.empty, "queue popped while empty")
  `PTS_ASSERT_NEVER(a_q_push_full, push_i && status_o.full, "queue pushed while full")
  `PTS_ASSERT(a_q_count_range, count_q <= QCntW'(QueueDepth), "queue count out of range")

endmodule

[rtl/pts_back.sv]
// ----------------------------------------------------------------------------
// Scheduler back end
// Holds the task table and executes commands; reschedule scans one slot a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pts_pkg::q_status_t q_status_i,
  input  pts_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pts_pkg::out_t      out_data_o
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    BackIdle = 3'b001,
    BackScan = 3'b010,
    BackFin  = 3'b100
  } back_state_e;

  back_state_e fsm_q, fsm_d;

  // Task table
  task_state_e tstate_q [TASKS+1];
  task_state_e tstate_d [TASKS+1];
  logic [7:0]  prio_q   [TASKS+1];
  logic [7:0]  prio_d   [TASKS+1];
  logic        flag_q   [TASKS];
  logic        flag_d   [TASKS];
  logic [31:0] cd_q     [TASKS];
  logic [31:0] cd_d     [TASKS];

  logic [TaskIdxW-1:0] cur_q, cur_d;
  logic [31:0]         tick_q, tick_d;

  // Scan registers
  logic [SlotW-1:0]    idx_q, idx_d;
  logic [SlotW-1:0]    cnt_q, cnt_d;
  logic [7:0]          best_q, best_d;
  logic [TaskIdxW-1:0] pick_q, pick_d;

  // Result register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic load;

  // Helpers
  logic                free_found;
  logic [SlotW-1:0]    low_free;
  logic [31:0]         delay_diff;
  logic [31:0]         delay_cd;
  logic [SlotW-1:0]    cur_slot;
  logic [SlotW-1:0]    start_idx;
  logic [TaskIdxW-1:0] scan_entry;
  logic [TaskIdxW-1:0] fin_pick;
  logic                cur_is_task;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop_o = (fsm_q == BackIdle) && !q_status_i.empty && (!out_valid_q || !out_stall_i);

  assign cur_is_task = (cur_q < TaskIdle);
  assign cur_slot    = SlotW'(cur_q);
  assign start_idx   = (!cur_is_task || cur_slot == SlotW'(TASKS - 1)) ? '0
                                                                       : SlotW'(cur_slot + 1'b1);
  assign scan_entry  = TaskIdxW'(idx_q);
  assign fin_pick    = (best_q == 8'd0) ? TaskIdle : pick_q;

  // Past or present target wakes on the next tick
  assign delay_diff = cmd_i.target - tick_q;
  assign delay_cd   = (delay_diff == 32'd0 || delay_diff[31]) ? 32'd1 : delay_diff;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    low_free   = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (tstate_q[i] == StFree) begin
        free_found = 1'b1;
        low_free   = SlotW'(i);
      end
    end
  end

  // Command execution and scan sequencing
  always_comb begin
    fsm_d  = fsm_q;
    cur_d  = cur_q;
    tick_d = tick_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    best_d = best_q;
    pick_d = pick_q;
    load   = 1'b0;
    for (int i = 0; i <= TASKS; i++) begin
      tstate_d[i] = tstate_q[i];
      prio_d[i]   = prio_q[i];
    end
    for (int i = 0; i < TASKS; i++) begin
      flag_d[i] = flag_q[i];
      cd_d[i]   = cd_q[i];
    end
    out_d.status   = StatusOk;
    out_d.new_task = '0;

    unique case (fsm_q)
      BackIdle: begin
        if (pop_o) begin
          load = 1'b1;
          unique case (cmd_i.op)
            OpTick: begin
              tick_d = tick_q + 32'd1;
              for (int i = 0; i < TASKS; i++) begin
                if (flag_q[i]) begin
                  cd_d[i] = cd_q[i] - 32'd1;
                  if (cd_q[i] == 32'd1) begin
                    flag_d[i]   = 1'b0;
                    tstate_d[i] = StRdy;
                  end
                end
              end
            end
            OpSched: begin
              load = 1'b0;
              if (tstate_q[cur_q] == StRun) begin
                tstate_d[cur_q] = StRdy;
              end
              idx_d  = start_idx;
              cnt_d  = '0;
              best_d = 8'd0;
              pick_d = TaskIdle;
              fsm_d  = BackScan;
            end
            OpCreate: begin
              if (!free_found) begin
                out_d.status = StatusNoSlot;
              end else begin
                tstate_d[TaskIdxW'(low_free)] = StRdy;
                prio_d[TaskIdxW'(low_free)]   = cmd_i.prio;
                flag_d[low_free]              = 1'b0;
                cd_d[low_free]                = 32'd0;
                out_d.new_task                = 3'(low_free);
              end
            end
            OpRejectPrio: begin
              out_d.status = StatusPrioZero;
            end
            OpDelay: begin
              if (cur_is_task) begin
                cd_d[cur_slot]   = delay_cd;
                flag_d[cur_slot] = 1'b1;
                tstate_d[cur_q]  = StBlk;
              end
            end
            OpBlock: begin
              if (cur_is_task) begin
                tstate_d[cur_q] = StBlk;
              end
            end
            OpUnblock: begin
              if (tstate_q[TaskIdxW'(cmd_i.slot)] == StBlk) begin
                tstate_d[TaskIdxW'(cmd_i.slot)] = StRdy;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BackScan: begin
        // one slot per cycle, strictly higher priority wins
        if (tstate_q[scan_entry] == StRdy && prio_q[scan_entry] > best_q) begin
          best_d = prio_q[scan_entry];
          pick_d = scan_entry;
        end
        idx_d = (idx_q == SlotW'(TASKS - 1)) ? '0 : SlotW'(idx_q + 1'b1);
        cnt_d = SlotW'(cnt_q + 1'b1);
        if (cnt_q == SlotW'(TASKS - 1)) begin
          fsm_d = BackFin;
        end
      end
      BackFin: begin
        tstate_d[fin_pick] = StRun;
        cur_d              = fin_pick;
        load               = 1'b1;
        fsm_d              = BackIdle;
      end
      default: begin
        fsm_d = BackIdle;
      end
    endcase

    out_d.running_task = 4'(cur_d);
    out_d.tick_count   = tick_d;
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= BackIdle;
      cur_q       <= TaskIdle;
      tick_q      <= 32'd0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      best_q      <= 8'd0;
      pick_q      <= TaskIdle;
      for (int i = 0; i <= TASKS; i++) begin
        tstate_q[i] <= (i == TASKS) ? StRun : StFree;
        prio_q[i]   <= 8'd0;
      end
      for (int i = 0; i < TASKS; i++) begin
        flag_q[i] <= 1'b0;
        cd_q[i]   <= 32'd0;
      end
    end else begin
      fsm_q       <= fsm_d;
      cur_q       <= cur_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      best_q      <= best_d;
      pick_q      <= pick_d;
      for (int i = 0; i <= TASKS; i++) begin
        tstate_q[i] <= tstate_d[i];
        prio_q[i]   <= prio_d[i];
      end
      for (int i = 0; i < TASKS; i++) begin
        flag_q[i] <= flag_d[i];
        cd_q[i]   <= cd_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  `PTS_ASSERT_NEVER(a_back_cur_range, cur_q > TaskIdle, "current task index out of range")
  `PTS_ASSERT(a_back_fin_runs, (fsm_q == BackFin) |=> (tstate_q[cur_q] == StRun),
              "picked task not marked running")
  `PTS_ASSERT(a_back_load_src,
              $rose(out_valid_q) |-> ($past(fsm_q == BackIdle) || $past(fsm_q == BackFin)),
              "result loaded outside idle or finish")

endmodule

[rtl/priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Priority task scheduler
// Task table of a small real-time kernel with round robin priority selection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one kernel event per transaction (tick, reschedule,
//   create, delay, block, unblock). Output channel returns exactly one result
//   per event: running task, status, created slot and the tick counter.
//   Both channels use valid/stall; a transaction completes when valid is high
//   and stall is low.
//   Path: a front register and a two-entry command queue lead into the
//   back end, which registers each result. A reschedule walks the task
//   table one slot per cycle in its scan state, then marks the winner
//   running in its finish state before the result is loaded.
//   Throughput: unless the output stalls, the back end retires one simple
//   event per cycle; a reschedule holds it through the scan and finish.
//   Reset: all slots free, the idle slot running, tick counter zero.
//   Output stall: the result register holds; the back end waits, the queue
//   fills and the input then stalls.
// ----------------------------------------------------------------------------
module priority_task_scheduler (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pts_pkg::out_t out_data_o
);
  import pts_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      front_cmd;
  cmd_t      back_cmd;

  // Accept and classify
  pts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // Decoupling queue
  pts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .pop_data_o  (back_cmd),
    .status_o    (q_status)
  );

  // Execute against the task table
  pts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
